// ===== design/rusph_pkg.sv =====
// shared types and constants for the ray / unit sphere intersection pipeline
`timescale 1ns / 1ps

package rusph_pkg;

    // square root steps: one root bit per stage, root below 2^58
    localparam int ROOT_W   = 58;
    // quotient bits produced by the divider chain
    localparam int QUO_W    = 31;
    // divider remainder width, covers num << FRAC_BITS and a << 31
    localparam int REM_W    = 96;
    localparam logic [QUO_W-1:0] DIST_MAX = {QUO_W{1'b1}};

    // word carried through the square root stages
    typedef struct packed {
        logic              miss;
        logic              hpos;
        logic [63:0]       hmag;
        logic [63:0]       a;
        logic [127:0]      disc;
        logic [ROOT_W-1:0] root;
        logic [127:0]      root_sq;
    } sq_t;

    // word carried through the divider stages
    typedef struct packed {
        logic             miss;
        logic             sat;
        logic [63:0]      a;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } dv_t;

endpackage

// ===== design/rusph_front.sv =====
// front stages: dot products, quadratic terms and discriminant
`timescale 1ns / 1ps

module rusph_front import rusph_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] ox,
    input  logic signed [31:0] oy,
    input  logic signed [31:0] oz,
    input  logic signed [31:0] dx,
    input  logic signed [31:0] dy,
    input  logic signed [31:0] dz,
    output logic               out_valid,
    output sq_t                out_data
);

    logic [5:0] v_reg;

    // stage 1 products
    logic signed [63:0] dd_reg [3];
    logic signed [63:0] oo_reg [3];
    logic signed [63:0] do_reg [3];
    // stage 2 sums
    logic [63:0]        a2_reg;
    logic [63:0]        oo2_reg;
    logic signed [65:0] h2_reg;
    // stage 3 magnitude of h
    logic [63:0]        a3_reg;
    logic [63:0]        oo3_reg;
    logic [63:0]        hmag3_reg;
    logic               hpos3_reg;
    // stage 4 partial products
    logic [63:0]        a4_reg;
    logic [63:0]        hmag4_reg;
    logic               hpos4_reg;
    logic               azero4_reg;
    logic [63:0]        hp_reg [4];
    logic [63:0]        qp_reg [4];
    // stage 5 p and q
    logic [63:0]        a5_reg;
    logic [63:0]        hmag5_reg;
    logic               hpos5_reg;
    logic               azero5_reg;
    logic [127:0]       p5_reg;
    logic [127:0]       q5_reg;
    // stage 6
    sq_t                out_reg;

    logic [63:0]  hmag_next;
    logic [127:0] p_next;
    logic [127:0] q_next;
    logic [127:0] a_shift;

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // negate h when it is negative, mod 2^64
    always_comb begin
        hmag_next = h2_reg[65] ? (64'd0 - h2_reg[63:0]) : h2_reg[63:0];
    end

    // assemble the 128-bit products from 32x32 partials; p also adds a << (2 * FRAC_BITS)
    always_comb begin
        a_shift = {64'd0, a4_reg} << (2 * FRAC_BITS);
        p_next  = {hp_reg[3], 64'd0} + ({64'd0, hp_reg[1]} << 32)
                + ({64'd0, hp_reg[2]} << 32) + {64'd0, hp_reg[0]} + a_shift;
        q_next  = {qp_reg[3], 64'd0} + ({64'd0, qp_reg[1]} << 32)
                + ({64'd0, qp_reg[2]} << 32) + {64'd0, qp_reg[0]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            dd_reg[0] <= dx * dx;
            dd_reg[1] <= dy * dy;
            dd_reg[2] <= dz * dz;
            oo_reg[0] <= ox * ox;
            oo_reg[1] <= oy * oy;
            oo_reg[2] <= oz * oz;
            do_reg[0] <= dx * ox;
            do_reg[1] <= dy * oy;
            do_reg[2] <= dz * oz;
            // stage 2
            a2_reg  <= $unsigned(dd_reg[0]) + $unsigned(dd_reg[1]) + $unsigned(dd_reg[2]);
            oo2_reg <= $unsigned(oo_reg[0]) + $unsigned(oo_reg[1]) + $unsigned(oo_reg[2]);
            h2_reg  <= {{2{do_reg[0][63]}}, do_reg[0]} + {{2{do_reg[1][63]}}, do_reg[1]}
                     + {{2{do_reg[2][63]}}, do_reg[2]};
            // stage 3
            a3_reg    <= a2_reg;
            oo3_reg   <= oo2_reg;
            hmag3_reg <= hmag_next;
            hpos3_reg <= !h2_reg[65] && (hmag_next != 64'd0);
            // stage 4
            a4_reg     <= a3_reg;
            hmag4_reg  <= hmag3_reg;
            hpos4_reg  <= hpos3_reg;
            azero4_reg <= (a3_reg == 64'd0);
            hp_reg[0]  <= hmag3_reg[31:0]  * hmag3_reg[31:0];
            hp_reg[1]  <= hmag3_reg[31:0]  * hmag3_reg[63:32];
            hp_reg[2]  <= hmag3_reg[63:32] * hmag3_reg[31:0];
            hp_reg[3]  <= hmag3_reg[63:32] * hmag3_reg[63:32];
            qp_reg[0]  <= a3_reg[31:0]  * oo3_reg[31:0];
            qp_reg[1]  <= a3_reg[31:0]  * oo3_reg[63:32];
            qp_reg[2]  <= a3_reg[63:32] * oo3_reg[31:0];
            qp_reg[3]  <= a3_reg[63:32] * oo3_reg[63:32];
            // stage 5
            a5_reg     <= a4_reg;
            hmag5_reg  <= hmag4_reg;
            hpos5_reg  <= hpos4_reg;
            azero5_reg <= azero4_reg;
            p5_reg     <= p_next;
            q5_reg     <= q_next;
            // stage 6: discriminant and early miss
            out_reg.miss    <= azero5_reg || (p5_reg < q5_reg);
            out_reg.hpos    <= hpos5_reg;
            out_reg.hmag    <= hmag5_reg;
            out_reg.a       <= a5_reg;
            out_reg.disc    <= p5_reg - q5_reg;
            out_reg.root    <= '0;
            out_reg.root_sq <= '0;
        end
    end

    assign out_valid = v_reg[5];
    assign out_data  = out_reg;

endmodule

// ===== design/rusph_sqrt_step.sv =====
// one stage of the square root: decides one root bit
`timescale 1ns / 1ps

module rusph_sqrt_step import rusph_pkg::*; #(
    parameter int BIT = 57
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  sq_t  in_data,
    output logic out_valid,
    output sq_t  out_data
);

    logic   valid_reg;
    sq_t    data_reg;
    sq_t    data_next;
    logic [127:0] trial_sq;

    // (r + bit)^2 = r^2 + r * 2 * bit + bit^2
    always_comb begin
        trial_sq  = in_data.root_sq + ({{(128-ROOT_W){1'b0}}, in_data.root} << (BIT + 1))
                  + (128'd1 << (2 * BIT));
        data_next = in_data;
        if (in_data.disc >= trial_sq) begin
            data_next.root    = in_data.root | (ROOT_W'(1) << BIT);
            data_next.root_sq = trial_sq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/rusph_div_step.sv =====
// one stage of the restoring divider: decides one quotient bit
`timescale 1ns / 1ps

module rusph_div_step import rusph_pkg::*; #(
    parameter int BIT = 30
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  dv_t  in_data,
    output logic out_valid,
    output dv_t  out_data
);

    logic             valid_reg;
    dv_t              data_reg;
    dv_t              data_next;
    logic [REM_W-1:0] sub;

    // subtract the shifted divisor when it fits
    always_comb begin
        sub       = {{(REM_W-64){1'b0}}, in_data.a} << BIT;
        data_next = in_data;
        if (in_data.rem >= sub) begin
            data_next.rem = in_data.rem - sub;
            data_next.quo = in_data.quo | (QUO_W'(1) << BIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/ray_unit_sphere_hit.sv =====
// Usage: a ray enters on the s_ channel as origin and direction in signed
// fixed point with FRAC_BITS fraction bits; one word per ray leaves on the
// m_ channel with m_hit and the distance t of the chosen root (unsigned,
// same fraction, saturated to all ones, zero on a miss).
// Throughput: one ray per cycle unless stalled, rays may arrive back to back.
// Stages: 6 front stages for the products and discriminant, 58 square
// root stages (one root bit each), a root select stage, a saturation check
// stage, 31 divider stages (one quotient bit each) and the output register.
// Stall: the whole pipeline holds while m_valid is high and m_ready low;
// s_ready then drops in the same cycle, nothing is lost or repeated.
// Bubbles in the pipeline are never squeezed out: all stages move together.
// Reset: synchronous active low aresetn clears all valid bits; the block
// is ready to accept in the first cycle after reset is released.
`timescale 1ns / 1ps

module ray_unit_sphere_hit import rusph_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_origin_x,
    input  logic signed [31:0] s_origin_y,
    input  logic signed [31:0] s_origin_z,
    input  logic signed [31:0] s_dir_x,
    input  logic signed [31:0] s_dir_y,
    input  logic signed [31:0] s_dir_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [30:0]        m_distance
);

    logic en;
    logic sq_valid [ROOT_W+1];
    sq_t  sq_data  [ROOT_W+1];
    logic dv_valid [QUO_W+1];
    dv_t  dv_data  [QUO_W+1];

    // pipeline advances whenever the output word is free or taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    rusph_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .ox        (s_origin_x),
        .oy        (s_origin_y),
        .oz        (s_origin_z),
        .dx        (s_dir_x),
        .dy        (s_dir_y),
        .dz        (s_dir_z),
        .out_valid (sq_valid[0]),
        .out_data  (sq_data[0])
    );

    // square root chain, most significant bit first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        rusph_sqrt_step #(.BIT(ROOT_W - 1 - k)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_data   (sq_data[k]),
            .out_valid (sq_valid[k+1]),
            .out_data  (sq_data[k+1])
        );
    end

    // root select: nearer root if non-negative, else farther root
    logic        sel_valid_reg;
    logic        sel_miss_reg;
    logic [63:0] sel_num_reg;
    logic [63:0] sel_a_reg;
    logic        sel_miss_next;
    logic [63:0] sel_num_next;
    logic [63:0] sf;
    logic [63:0] sc;
    sq_t         rt;

    always_comb begin
        rt            = sq_data[ROOT_W];
        sf            = {{(64-ROOT_W){1'b0}}, rt.root};
        sc            = sf + {63'd0, (rt.root_sq != rt.disc)};
        sel_miss_next = rt.miss;
        sel_num_next  = '0;
        if (!rt.hpos && rt.hmag >= sc) begin
            sel_num_next = rt.hmag - sc;
        end else if (!rt.hpos) begin
            sel_num_next = rt.hmag + sf;
        end else if (sf >= rt.hmag) begin
            sel_num_next = sf - rt.hmag;
        end else begin
            sel_miss_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
        end else if (en) begin
            sel_valid_reg <= sq_valid[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel_miss_reg <= sel_miss_next;
            sel_num_reg  <= sel_num_next;
            sel_a_reg    <= rt.a;
        end
    end

    // saturation check: quotient reaches 2^31 when num << F >= a << 31
    logic             sat_valid_reg;
    dv_t              sat_reg;
    logic [REM_W-1:0] dividend;
    logic [REM_W-1:0] a_top;

    always_comb begin
        dividend = {{(REM_W-64){1'b0}}, sel_num_reg} << FRAC_BITS;
        a_top    = {{(REM_W-64){1'b0}}, sel_a_reg} << QUO_W;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_valid_reg <= 1'b0;
        end else if (en) begin
            sat_valid_reg <= sel_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg.miss <= sel_miss_reg;
            sat_reg.sat  <= (dividend >= a_top);
            sat_reg.a    <= sel_a_reg;
            sat_reg.rem  <= dividend;
            sat_reg.quo  <= '0;
        end
    end

    assign dv_valid[0] = sat_valid_reg;
    assign dv_data[0]  = sat_reg;

    // divider chain, most significant quotient bit first
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        rusph_div_step #(.BIT(QUO_W - 1 - k)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_valid[k]),
            .in_data   (dv_data[k]),
            .out_valid (dv_valid[k+1]),
            .out_data  (dv_data[k+1])
        );
    end

    // output word
    logic        out_valid_reg;
    logic        out_hit_reg;
    logic [30:0] out_dist_reg;
    dv_t         fin;

    assign fin = dv_data[QUO_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_hit_reg  <= !fin.miss;
            out_dist_reg <= fin.miss ? '0 : (fin.sat ? DIST_MAX : fin.quo);
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_hit      = out_hit_reg;
    assign m_distance = out_dist_reg;

`ifndef SYNTH
    // a miss always reports zero distance
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_distance == '0)
        else $error("miss with nonzero distance");

    // no word leaves right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // the input side stalls exactly when the output word is held
    a_stall_link: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the ray / unit sphere intersection pipeline
`timescale 1ns / 1ps

module testbench;
    import rusph_pkg::*;

    localparam int FRAC = 16;
    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam int RANDOM_RAYS = 1425;
    localparam int LATENCY = 98;

    typedef struct {
        logic        hit;
        logic [30:0] distance;
    } hit_word_t;

    // expected hit words in acceptance order, plus the exact hit predictor
    class hit_scoreboard;
        hit_word_t pending_hits[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function int depth();
            return pending_hits.size();
        endfunction

        // exact integer intersection of one ray with the unit sphere
        function void note_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                               logic signed [31:0] oz, logic signed [31:0] dx,
                               logic signed [31:0] dy, logic signed [31:0] dz);
            logic signed [63:0] px, py, pz;
            logic [63:0] a, oo, hmag, sf, sc, num, t;
            logic signed [127:0] h;
            logic [127:0] p, q, disc, numer, quo;
            logic hneg, hpos;
            hit_word_t w;
            w.hit = 1'b0;
            w.distance = '0;
            px = dx * dx; py = dy * dy; pz = dz * dz;
            a = px + py + pz;
            px = ox * ox; py = oy * oy; pz = oz * oz;
            oo = px + py + pz;
            px = dx * ox; py = dy * oy; pz = dz * oz;
            h = 128'(px) + 128'(py) + 128'(pz);
            hneg = h[127];
            hmag = hneg ? 64'(-h[63:0]) : h[63:0];
            hpos = !hneg && hmag != 0;
            if (a != 0) begin
                p = 128'(hmag) * 128'(hmag) + (128'(a) << (2 * FRAC));
                q = 128'(a) * 128'(oo);
                if (p >= q) begin
                    disc = p - q;
                    // bitwise integer square root, root below 2^58
                    sf = 0;
                    for (int b = 57; b >= 0; b--) begin
                        t = sf | (64'd1 << b);
                        if (!(disc < 128'(t) * 128'(t))) sf = t;
                    end
                    sc = sf + ((128'(sf) * 128'(sf) == disc) ? 64'd0 : 64'd1);
                    w.hit = 1'b1;
                    if (!hpos && hmag >= sc) num = hmag - sc;
                    else if (!hpos) num = hmag + sf;
                    else if (sf >= hmag) num = sf - hmag;
                    else w.hit = 1'b0;
                    if (w.hit) begin
                        numer = 128'(num) << FRAC;
                        quo = numer / 128'(a);
                        w.distance = (quo > 128'(DIST_MAX)) ? DIST_MAX : quo[30:0];
                    end
                end
            end
            pending_hits.push_back(w);
        endfunction

        function void check_word(logic hit, logic [30:0] distance);
            hit_word_t w;
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected word hit=%0b distance=%h", $time, hit, distance);
                errors++;
                return;
            end
            w = pending_hits.pop_front();
            if (hit !== w.hit) begin
                $display("%0t: hit expected %0b actual %0b", $time, w.hit, hit);
                errors++;
            end
            if (distance !== w.distance) begin
                $display("%0t: distance expected %h actual %h", $time, w.distance, distance);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    logic signed [31:0] s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [30:0] m_distance;

    hit_scoreboard sb = new();
    bit long_hold = 1'b0;
    bit calm = 1'b0;

    ray_unit_sphere_hit #(.FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_distance(m_distance)
    );

    always #2 aclk = ~aclk;

    // gap length: mostly none or short, a few long
    function int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one ray after a random gap and wait until it is taken
    task send_ray(logic signed [31:0] ox, logic signed [31:0] oy, logic signed [31:0] oz,
                  logic signed [31:0] dx, logic signed [31:0] dy, logic signed [31:0] dz);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_origin_x <= ox; s_origin_y <= oy; s_origin_z <= oz;
        s_dir_x <= dx; s_dir_y <= dy; s_dir_z <= dz;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_ray(ox, oy, oz, dx, dy, dz);
        @(negedge aclk);
    endtask

    // random component in the range -span to span
    function logic signed [31:0] near_val(int span);
        return $signed(32'($urandom_range(0, 2 * span))) - $signed(32'(span));
    endfunction

    task send_random_ray();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            send_ray(near_val(4 * 65536), near_val(4 * 65536), near_val(4 * 65536),
                     near_val(2 * 65536), near_val(2 * 65536), near_val(2 * 65536));
        end else if (kind < 8) begin
            // short directions drive the distance into saturation
            send_ray(near_val(3 * 65536), near_val(3 * 65536), near_val(3 * 65536),
                     near_val(64), near_val(64), near_val(64));
        end else begin
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // stimulus
    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // zero direction
        send_ray(0, 0, -2 * ONE, 0, 0, 0);
        // from the center outward
        send_ray(0, 0, 0, ONE, 0, 0);
        send_ray(0, 0, 0, 0, 0, -3 * ONE);
        // straight hit from outside
        send_ray(0, 0, -2 * ONE, 0, 0, ONE);
        // tangent
        send_ray(ONE, 0, -2 * ONE, 0, 0, ONE);
        // no real root
        send_ray(2 * ONE, 0, -2 * ONE, 0, 0, ONE);
        // both roots behind the origin
        send_ray(0, 0, 2 * ONE, 0, 0, ONE);
        // origin on the sphere, going out and going in
        send_ray(ONE, 0, 0, ONE, 0, 0);
        send_ray(ONE, 0, 0, -ONE, 0, 0);
        // distance saturates
        send_ray(0, 0, -2 * ONE, 0, 0, 1);
        send_ray(0, 0, 0, 1, 0, 0);
        // field extremes
        send_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_ray(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, -1);
        send_ray(0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_ray(-1, -1, -1, -1, -1, -1);
        send_ray(0, 0, 0, 32'sh7fffffff, 0, 0);
        for (int i = 0; i < RANDOM_RAYS; i++) begin
            if (i == 300) long_hold = 1'b1;
            if (i == 700) begin
                s_valid <= 1'b0;
                while (sb.depth() != 0) @(negedge aclk);
            end
            if (i % 250 == 100) calm = 1'b1;
            if (i % 250 == 160) calm = 1'b0;
            send_random_ray();
        end
        s_valid <= 1'b0;
        while (sb.depth() != 0) @(negedge aclk);
        repeat (LATENCY + 20) @(negedge aclk);
        if (sb.errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    // result side: random ready, one long hold to back up the pipeline
    initial begin
        int gap;
        @(negedge aclk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
        end
    end

    // check every word taken from the result channel
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_hit, m_distance);
    end

    // overall time limit
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
